@@ src/spectrum_band_bar_meter_assert.svh @@
// assertion macros for the spectrum band bar meter
`ifndef SPECTRUM_BAND_BAR_METER_ASSERT_SVH
`define SPECTRUM_BAND_BAR_METER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define SBBM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define SBBM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/sbbm_pkg.sv @@
// shared types and constants for the spectrum band bar meter
`timescale 1ns / 1ps

package sbbm_pkg;

  localparam int BAND_COUNT     = 16;
  localparam int BAND_W         = 4;
  localparam int EDGE_COUNT     = 15;
  localparam int BIN_W          = 8;
  localparam int MAG_W          = 22;
  localparam int SUM_W          = 32;
  localparam int DIVISOR_W      = 16;
  localparam int HEIGHT_W       = 8;
  localparam int FFT_POINTS_DEF = 512;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [BIN_W-1:0]     LOW_BIN       = 8'd2;
  localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd1000;
  localparam logic [HEIGHT_W-1:0]  BAR_TOP_RESET = 8'd48;

  typedef logic [8:0] edge_t;

  // upper bin edge of each band but the last
  localparam edge_t BAND_EDGE [EDGE_COUNT] = '{
    9'd2, 9'd3, 9'd5, 9'd7, 9'd9, 9'd13, 9'd18, 9'd25,
    9'd36, 9'd50, 9'd69, 9'd97, 9'd135, 9'd189, 9'd264
  };

  typedef enum logic {
    REG_SENSITIVITY = 1'b0,
    REG_BAR_TOP     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic              add_en;
    logic [BAND_W-1:0] band;
    logic [MAG_W-1:0]  mag;
    logic              last;
  } bin_entry_t;

  typedef struct packed {
    logic                 start;
    logic [SUM_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ src/sbbm_front.sv @@
// front end: takes a bin, picks its band and queues it
`timescale 1ns / 1ps

module sbbm_front import sbbm_pkg::*; #(
  parameter int FFT_POINTS = FFT_POINTS_DEF
) (
  input  logic              start,
  input  logic [BIN_W-1:0]  bin_index,
  input  logic [MAG_W-1:0]  magnitude,
  input  logic              frame_end,
  input  logic              fifo_full,
  output logic              push,
  output bin_entry_t        entry
);

  logic [EDGE_COUNT-1:0] above_edge;
  logic                  in_range;

  // band number is the count of edges the bin lies above
  always_comb begin
    for (int i = 0; i < EDGE_COUNT; i++) begin
      above_edge[i] = {1'b0, bin_index} > BAND_EDGE[i];
    end
  end

  assign in_range = (bin_index >= LOW_BIN) &&
                    (32'(bin_index) < 32'(FFT_POINTS / 2));

  assign push         = start && !fifo_full;
  assign entry.add_en = in_range;
  assign entry.band   = BAND_W'($countones(above_edge));
  assign entry.mag    = magnitude;
  assign entry.last   = frame_end;

endmodule

@@ src/sbbm_fifo.sv @@
// short queue between front and back
`timescale 1ns / 1ps

module sbbm_fifo import sbbm_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  bin_entry_t push_data,
  input  logic       pop,
  output bin_entry_t head,
  output logic       empty,
  output logic       full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bin_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/sbbm_div.sv @@
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module sbbm_div import sbbm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(SUM_W);

  logic                 running;
  logic                 done;
  logic [CNT_W-1:0]     step;
  logic [SUM_W-1:0]     quo;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   shifted;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  assign shifted = {rem, quo[SUM_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  // zero divisor always fits, giving an all-ones quotient
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (running) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == CNT_W'(SUM_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

@@ src/sbbm_back.sv @@
// back end: band sums, frame-end band walk, heights and peaks
`timescale 1ns / 1ps

module sbbm_back import sbbm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  bin_entry_t           head,
  input  logic                 fifo_empty,
  output logic                 pop,
  input  logic [DIVISOR_W-1:0] sensitivity_divisor,
  input  logic [HEIGHT_W-1:0]  bar_top,
  output div_req_t             div_req,
  input  div_rsp_t             div_rsp,
  output logic                 strobe,
  output logic [BAND_W-1:0]    band_number,
  output logic [HEIGHT_W-1:0]  bar_height,
  output logic [HEIGHT_W-1:0]  peak_height,
  output logic                 last_band
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_WAIT = 4'b0100,
    S_EMIT = 4'b1000
  } back_state_t;

  back_state_t          state;
  logic [SUM_W-1:0]     sums   [BAND_COUNT];
  logic [HEIGHT_W-1:0]  priors [BAND_COUNT];
  logic [HEIGHT_W-1:0]  peaks  [BAND_COUNT];
  logic [BAND_W-1:0]    band_cnt;

  logic [BAND_W-1:0]    addr;
  logic [SUM_W-1:0]     sum_rd;
  logic [SUM_W:0]       sum_add;
  logic [SUM_W-1:0]     sum_sat;
  logic [HEIGHT_W-1:0]  raw;
  logic [HEIGHT_W:0]    avg_sum;
  logic [HEIGHT_W-1:0]  height_next;
  logic [HEIGHT_W-1:0]  peak_cur;
  logic [HEIGHT_W-1:0]  peak_next;
  logic                 walk_last;

  // one read port on the sums: queue head when idle, walk counter otherwise
  assign addr    = (state == S_IDLE) ? head.band : band_cnt;
  assign sum_rd  = sums[addr];
  assign sum_add = {1'b0, sum_rd} + (SUM_W + 1)'(head.mag);
  assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

  assign pop = (state == S_IDLE) && !fifo_empty;

  assign div_req.start    = (state == S_LOAD);
  assign div_req.dividend = sum_rd;
  assign div_req.divisor  = sensitivity_divisor;

  assign raw         = (div_rsp.quotient > SUM_W'(bar_top)) ? bar_top
                                                             : div_rsp.quotient[HEIGHT_W-1:0];
  assign avg_sum     = {1'b0, priors[band_cnt]} + {1'b0, raw};
  assign height_next = avg_sum[HEIGHT_W:1];
  assign peak_cur    = peaks[band_cnt];
  assign peak_next   = (height_next > peak_cur)
                       ? ((height_next < bar_top) ? height_next : bar_top)
                       : peak_cur;
  assign walk_last   = (band_cnt == BAND_W'(BAND_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      band_cnt <= '0;
      strobe   <= 1'b0;
      for (int i = 0; i < BAND_COUNT; i++) begin
        sums[i]   <= '0;
        priors[i] <= '0;
        peaks[i]  <= '0;
      end
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            if (head.add_en) begin
              sums[addr] <= sum_sat;
            end
            if (head.last) begin
              band_cnt <= '0;
              state    <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          sums[addr]       <= '0;
          priors[band_cnt] <= height_next;
          peaks[band_cnt]  <= peak_next;
          strobe           <= 1'b1;
          band_cnt         <= band_cnt + 1'b1;
          state            <= walk_last ? S_IDLE : S_LOAD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      band_number <= band_cnt;
      bar_height  <= height_next;
      peak_height <= peak_next;
      last_band   <= walk_last;
    end
  end

endmodule

@@ src/spectrum_band_bar_meter.sv @@
// top level of the spectrum band bar meter with peak hold
//
//   channel  | signals                                    | flow
//   ---------+--------------------------------------------+--------------------------
//   bin in   | start, busy, bin_index, magnitude,         | taken when start & !busy
//            | frame_end                                  |
//   bar out  | strobe, band_number, bar_height,           | one cycle per transaction,
//            | peak_height, last_band                     | no back-pressure
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data  | taken when valid & ready
//
// bins are taken one per cycle while the queue has room; the back end drains
// one plain bin per cycle while idle, not during a band walk. a frame end runs
// a band walk through the shared divider, one band at a time.
// busy rises only while the queue is full. reset clears sums, heights, peaks
// and the queue and restores the config registers.
`timescale 1ns / 1ps

module spectrum_band_bar_meter import sbbm_pkg::*; #(
  parameter int FFT_POINTS = FFT_POINTS_DEF,
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [BIN_W-1:0]     bin_index,
  input  logic [MAG_W-1:0]     magnitude,
  input  logic                 frame_end,
  output logic                 strobe,
  output logic [BAND_W-1:0]    band_number,
  output logic [HEIGHT_W-1:0]  bar_height,
  output logic [HEIGHT_W-1:0]  peak_height,
  output logic                 last_band,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [DIVISOR_W-1:0] cfg_data
);

`include "spectrum_band_bar_meter_assert.svh"

  logic [DIVISOR_W-1:0] sensitivity_divisor;
  logic [HEIGHT_W-1:0]  bar_top;
  logic                 push;
  bin_entry_t           push_entry;
  bin_entry_t           head;
  logic                 fifo_empty;
  logic                 fifo_full;
  logic                 pop;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  assign cfg_ready = 1'b1;
  assign busy      = fifo_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity_divisor <= DIVISOR_RESET;
      bar_top             <= BAR_TOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SENSITIVITY: sensitivity_divisor <= cfg_data;
        REG_BAR_TOP:     bar_top             <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  sbbm_front #(
    .FFT_POINTS (FFT_POINTS)
  ) u_front (
    .start     (start),
    .bin_index (bin_index),
    .magnitude (magnitude),
    .frame_end (frame_end),
    .fifo_full (fifo_full),
    .push      (push),
    .entry     (push_entry)
  );

  sbbm_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .head      (head),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  sbbm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  sbbm_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .head                (head),
    .fifo_empty          (fifo_empty),
    .pop                 (pop),
    .sensitivity_divisor (sensitivity_divisor),
    .bar_top             (bar_top),
    .div_req             (div_req),
    .div_rsp             (div_rsp),
    .strobe              (strobe),
    .band_number         (band_number),
    .bar_height          (bar_height),
    .peak_height         (peak_height),
    .last_band           (last_band)
  );

  // the queue must never be written while full
  `SBBM_ASSERT_NOW(a_no_push_full, push, !fifo_full, "push into full queue")
  // the final-band flag belongs to the top band only
  `SBBM_ASSERT_NOW(a_last_band_num, strobe && last_band,
                   band_number == BAND_W'(BAND_COUNT - 1), "last band flag on wrong band")
  // every band waits on the divider, so results never come back to back
  `SBBM_ASSERT_NEXT(a_strobe_gap, strobe, !strobe, "results on consecutive cycles")

endmodule
